// ===== rtl/dmacc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmacc_pkg
// Shared types and codes of the four-channel DMA channel controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dmacc_pkg;

    localparam int NUM_CH = 4;

    // op codes
    localparam logic [2:0] OP_REG_WR     = 3'd0;
    localparam logic [2:0] OP_REG_RD     = 3'd1;
    localparam logic [2:0] OP_MEM_TO_DEV = 3'd2;
    localparam logic [2:0] OP_DEV_TO_MEM = 3'd3;
    localparam logic [2:0] OP_RESET      = 3'd4;
    localparam logic [2:0] OP_PAGE_WR    = 3'd5;

    // register offsets above the address/count block
    localparam logic [3:0] REG_STATUS       = 4'd8;
    localparam logic [3:0] REG_REQUEST      = 4'd9;
    localparam logic [3:0] REG_MASK_BIT     = 4'd10;
    localparam logic [3:0] REG_MODE         = 4'd11;
    localparam logic [3:0] REG_FF_CLEAR     = 4'd12;
    localparam logic [3:0] REG_MASTER_CLEAR = 4'd13;
    localparam logic [3:0] REG_MASK_CLEAR   = 4'd14;
    localparam logic [3:0] REG_MASK_SET     = 4'd15;

    // mode transfer kinds
    localparam logic [1:0] XK_DEV_TO_MEM = 2'd1;
    localparam logic [1:0] XK_MEM_TO_DEV = 2'd2;

    // memory request codes
    localparam logic [1:0] MREQ_NONE  = 2'd0;
    localparam logic [1:0] MREQ_READ  = 2'd1;
    localparam logic [1:0] MREQ_WRITE = 2'd2;

    localparam logic [7:0] STATUS_RESET = 8'h0f;
    localparam logic [7:0] READ_IDLE    = 8'hff;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] reg_index;
        logic [1:0] chan_sel;
        logic [7:0] data_in;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  mem_request;
        logic [23:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        terminal_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dmacc_in_if.sv =====
// ----------------------------------------------------------------------------
// dmacc_in_if
// Event channel into the DMA channel controller.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmacc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [3:0] reg_index;
    logic [1:0] chan_sel;
    logic [7:0] data_in;

    modport source (output valid, output op, output reg_index, output chan_sel,
                    output data_in, input ready);
    modport sink   (input valid, input op, input reg_index, input chan_sel,
                    input data_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmacc_out_if.sv =====
// ----------------------------------------------------------------------------
// dmacc_out_if
// Result channel out of the DMA channel controller.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmacc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  mem_request;
    logic [23:0] mem_address;
    logic [7:0]  mem_write_data;
    logic        terminal_count;

    modport source (output valid, output read_data, output mem_request,
                    output mem_address, output mem_write_data,
                    output terminal_count, input ready);
    modport sink   (input valid, input read_data, input mem_request,
                    input mem_address, input mem_write_data,
                    input terminal_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmacc_in_stage.sv =====
// ----------------------------------------------------------------------------
// dmacc_in_stage
// Input register: holds one event beat until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmacc_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire dmacc_pkg::t_item  i_item,
    output logic                   o_ready,
    input  wire logic              i_take,
    output logic                   o_valid,
    output dmacc_pkg::t_item       o_item
);

    logic             r_valid;
    logic             n_valid;
    dmacc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/dmacc_core.sv =====
// ----------------------------------------------------------------------------
// dmacc_core
// Channel register file, status/mask/temp registers and the combinational
// update and result logic for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module dmacc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_fire,
    input  wire dmacc_pkg::t_item  i_item,
    output dmacc_pkg::t_result     o_result
);

    logic [15:0] r_cur_address [dmacc_pkg::NUM_CH];
    logic [15:0] r_cur_count   [dmacc_pkg::NUM_CH];
    logic [1:0]  r_xfer_kind   [dmacc_pkg::NUM_CH];
    logic        r_step_down   [dmacc_pkg::NUM_CH];
    logic [7:0]  r_page        [dmacc_pkg::NUM_CH];
    logic        r_high_byte;
    logic [7:0]  r_status;
    logic [7:0]  r_mask;
    logic [7:0]  r_temp;
    logic        r_wide_pages;

    logic [15:0] n_cur_address [dmacc_pkg::NUM_CH];
    logic [15:0] n_cur_count   [dmacc_pkg::NUM_CH];
    logic [1:0]  n_xfer_kind   [dmacc_pkg::NUM_CH];
    logic        n_step_down   [dmacc_pkg::NUM_CH];
    logic [7:0]  n_page        [dmacc_pkg::NUM_CH];
    logic        n_high_byte;
    logic [7:0]  n_status;
    logic [7:0]  n_mask;
    logic [7:0]  n_temp;

    logic        is_xfer;
    logic [1:0]  ch;
    logic [1:0]  d_ch;
    logic [15:0] cur_a;
    logic [15:0] cur_c;
    logic [15:0] sel_val;
    logic [15:0] loaded;
    logic [7:0]  d;

    assign d       = i_item.data_in;
    assign d_ch    = d[1:0];
    assign is_xfer = (i_item.op == dmacc_pkg::OP_MEM_TO_DEV) ||
                     (i_item.op == dmacc_pkg::OP_DEV_TO_MEM);
    assign ch      = is_xfer ? i_item.chan_sel : i_item.reg_index[2:1];
    assign cur_a   = r_cur_address[ch];
    assign cur_c   = r_cur_count[ch];
    assign sel_val = i_item.reg_index[0] ? cur_c : cur_a;
    // second byte ORs into the high half, first byte replaces the word
    assign loaded  = r_high_byte ? (sel_val | {d, 8'h00}) : {8'h00, d};

    always_comb begin
        n_cur_address = r_cur_address;
        n_cur_count   = r_cur_count;
        n_xfer_kind   = r_xfer_kind;
        n_step_down   = r_step_down;
        n_page        = r_page;
        n_high_byte   = r_high_byte;
        n_status      = r_status;
        n_mask        = r_mask;
        n_temp        = r_temp;

        o_result.read_data      = dmacc_pkg::READ_IDLE;
        o_result.mem_request    = dmacc_pkg::MREQ_NONE;
        o_result.mem_address    = 24'h000000;
        o_result.mem_write_data = 8'h00;
        o_result.terminal_count = 1'b0;

        case (i_item.op)
            dmacc_pkg::OP_REG_WR: begin
                if (!i_item.reg_index[3]) begin
                    if (i_item.reg_index[0]) begin
                        n_cur_count[ch] = loaded;
                    end else begin
                        n_cur_address[ch] = loaded;
                    end
                    n_high_byte = !r_high_byte;
                end else begin
                    case (i_item.reg_index)
                        dmacc_pkg::REG_REQUEST: begin
                            if (d[2]) begin
                                n_status[{1'b1, d_ch}] = 1'b1;
                            end else begin
                                n_status[{1'b1, d_ch}] = 1'b0;
                                n_status[{1'b0, d_ch}] = 1'b0;
                            end
                        end
                        dmacc_pkg::REG_MASK_BIT: begin
                            n_mask[{1'b1, d_ch}] = d[2];
                            n_mask[{1'b0, d_ch}] = d[2];
                        end
                        dmacc_pkg::REG_MODE: begin
                            n_xfer_kind[d_ch] = d[3:2];
                            n_step_down[d_ch] = d[5];
                        end
                        dmacc_pkg::REG_FF_CLEAR: begin
                            n_temp      = d;
                            n_high_byte = 1'b0;
                        end
                        dmacc_pkg::REG_MASTER_CLEAR: begin
                            n_high_byte = 1'b0;
                        end
                        dmacc_pkg::REG_MASK_CLEAR: begin
                            n_mask = r_mask & ~d;
                        end
                        dmacc_pkg::REG_MASK_SET: begin
                            n_mask = r_mask | d;
                        end
                        default: begin
                            // command register: ignored
                        end
                    endcase
                end
            end
            dmacc_pkg::OP_REG_RD: begin
                if (!i_item.reg_index[3]) begin
                    o_result.read_data = r_high_byte ? sel_val[15:8] : sel_val[7:0];
                    n_high_byte        = !r_high_byte;
                end else begin
                    case (i_item.reg_index)
                        dmacc_pkg::REG_STATUS:       o_result.read_data = r_status | 8'h01;
                        dmacc_pkg::REG_MASK_BIT:     o_result.read_data = r_mask;
                        dmacc_pkg::REG_MASTER_CLEAR: o_result.read_data = r_temp;
                        default:                     o_result.read_data = dmacc_pkg::READ_IDLE;
                    endcase
                end
            end
            dmacc_pkg::OP_MEM_TO_DEV, dmacc_pkg::OP_DEV_TO_MEM: begin
                if (i_item.op == dmacc_pkg::OP_MEM_TO_DEV &&
                    r_xfer_kind[ch] == dmacc_pkg::XK_MEM_TO_DEV) begin
                    o_result.mem_request = dmacc_pkg::MREQ_READ;
                    o_result.mem_address = {r_page[ch], cur_a};
                end else if (i_item.op == dmacc_pkg::OP_DEV_TO_MEM &&
                             r_xfer_kind[ch] == dmacc_pkg::XK_DEV_TO_MEM) begin
                    o_result.mem_request    = dmacc_pkg::MREQ_WRITE;
                    o_result.mem_address    = {r_page[ch], cur_a};
                    o_result.mem_write_data = d;
                end
                n_cur_address[ch] = r_step_down[ch] ? (cur_a - 16'd1) : (cur_a + 16'd1);
                n_cur_count[ch]   = cur_c - 16'd1;
                // count wraps from zero: terminal count
                if (cur_c == 16'h0000) begin
                    o_result.terminal_count = 1'b1;
                    n_status[{1'b1, ch}]    = 1'b0;
                    n_status[{1'b0, ch}]    = 1'b1;
                end
            end
            dmacc_pkg::OP_RESET: begin
                n_status = dmacc_pkg::STATUS_RESET;
                for (int i = 0; i < dmacc_pkg::NUM_CH; i++) begin
                    n_xfer_kind[i] = 2'd0;
                end
            end
            dmacc_pkg::OP_PAGE_WR: begin
                n_page[i_item.chan_sel] = r_wide_pages ? d : {4'h0, d[3:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dmacc_pkg::NUM_CH; i++) begin
                r_cur_address[i] <= 16'h0000;
                r_cur_count[i]   <= 16'h0000;
                r_xfer_kind[i]   <= 2'd0;
                r_step_down[i]   <= 1'b0;
                r_page[i]        <= 8'h00;
            end
            r_high_byte  <= 1'b0;
            r_status     <= dmacc_pkg::STATUS_RESET;
            r_mask       <= 8'h00;
            r_temp       <= 8'h00;
            r_wide_pages <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_wide_pages <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_cur_address <= n_cur_address;
                r_cur_count   <= n_cur_count;
                r_xfer_kind   <= n_xfer_kind;
                r_step_down   <= n_step_down;
                r_page        <= n_page;
                r_high_byte   <= n_high_byte;
                r_status      <= n_status;
                r_mask        <= n_mask;
                r_temp        <= n_temp;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmacc_out_stage.sv =====
// ----------------------------------------------------------------------------
// dmacc_out_stage
// Result register: holds a result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmacc_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire dmacc_pkg::t_result  i_result,
    output logic                     o_free,
    output logic                     o_valid,
    output dmacc_pkg::t_result       o_result,
    input  wire logic                i_ready
);

    logic               r_valid;
    logic               n_valid;
    dmacc_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/dma_channel_controller.sv =====
// ----------------------------------------------------------------------------
// dma_channel_controller
// Four-channel DMA controller: register accesses, transfer steps, page writes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one event beat (op, reg_index, chan_sel, data_in) with
//   valid/ready. o_out returns exactly one result beat per event, in order:
//   read_data, mem_request, mem_address, mem_write_data, terminal_count.
//   i_cfg_wr_en/i_cfg_wr_data write the wide_pages bit; write it only while
//   no event is in flight.
//   An accepted event is held in the input register and loads the result
//   register once that is free; the receiver can then take the result beat.
//   Throughput: one event per cycle while the receiver does not stall; the channel
//   state updates in the same cycle the result register loads, so back-to-back events see each other.
//   Reset (i_rst_n low, synchronous) clears both stage registers and the
//   channel state, sets status to 0x0f and wide_pages to 1.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more beat; after that i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_channel_controller (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    dmacc_in_if.sink    i_in,
    dmacc_out_if.source o_out
);

    dmacc_pkg::t_item   in_item;
    dmacc_pkg::t_item   q_item;
    dmacc_pkg::t_result core_result;
    dmacc_pkg::t_result out_result;
    logic               q_valid;
    logic               out_free;
    logic               fire;
    logic               in_ready;
    logic               out_valid;

    assign in_item.op        = i_in.op;
    assign in_item.reg_index = i_in.reg_index;
    assign in_item.chan_sel  = i_in.chan_sel;
    assign in_item.data_in   = i_in.data_in;

    assign fire = q_valid && out_free;

    dmacc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (in_ready),
        .i_take  (fire),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dmacc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (q_item),
        .o_result      (core_result)
    );

    dmacc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result),
        .i_ready  (o_out.ready)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.read_data       = out_result.read_data;
    assign o_out.mem_request     = out_result.mem_request;
    assign o_out.mem_address     = out_result.mem_address;
    assign o_out.mem_write_data  = out_result.mem_write_data;
    assign o_out.terminal_count  = out_result.terminal_count;

endmodule

`default_nettype wire

// ===== tb/dma_channel_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_channel_controller_tb
// Self-checking bench for the four-channel DMA channel controller. A queue
// of event beats feeds a valid/ready driver. Accepted beats run through an
// in-bench model of the channel registers. Every result beat is compared
// field by field against the oldest predicted result. Directed register and
// transfer cases come first. Random programming sequences, transfer bursts
// and noise follow under both page widths, with random stalls on both sides.
// ----------------------------------------------------------------------------
module dma_channel_controller_tb;
    import dmacc_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 4;
    localparam logic [7:0]  PAGE_NARROW  = 8'h0f;
    localparam logic [15:0] COUNT_WRAP   = 16'hffff;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    dmacc_in_if  in_if ();
    dmacc_out_if out_if ();

    dma_channel_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // model of the channel state
    logic [15:0] ch_addr  [NUM_CH];
    logic [15:0] ch_count [NUM_CH];
    logic [1:0]  ch_kind  [NUM_CH];
    logic        ch_down  [NUM_CH];
    logic [7:0]  ch_page  [NUM_CH];
    logic        byte_ff;
    logic [7:0]  status_q;
    logic [7:0]  mask_q;
    logic [7:0]  temp_q;
    logic        wide_q;

    t_item   pending_beats [$];
    t_result expected_results [$];

    int unsigned n_pushed   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_mem      = 0;
    int unsigned n_tc       = 0;
    int unsigned n_errors   = 0;
    int unsigned cycles     = 0;
    int unsigned src_gap    = 0;
    int unsigned snk_stall  = 0;
    logic        in_taken   = 1'b0;
    logic        idle_en    = 1'b1;
    logic        idle_now   = 1'b1;

    task automatic reset_model();
        for (int i = 0; i < NUM_CH; i++) begin
            ch_addr[i]  = '0;
            ch_count[i] = '0;
            ch_kind[i]  = '0;
            ch_down[i]  = 1'b0;
            ch_page[i]  = '0;
        end
        byte_ff  = 1'b0;
        status_q = STATUS_RESET;
        mask_q   = '0;
        temp_q   = '0;
        wide_q   = 1'b1;
    endtask

    // low byte replaces the word, high byte is ORed in; flip-flop toggles
    function automatic logic [15:0] merge_byte(logic [15:0] old, logic [7:0] b);
        logic [15:0] v;
        v = byte_ff ? (old | {b, 8'h00}) : {8'h00, b};
        byte_ff = ~byte_ff;
        return v;
    endfunction

    function automatic t_result dma_predict(t_item it);
        t_result     r;
        logic [1:0]  dch;
        logic [1:0]  ch;
        logic [15:0] v;
        r = '0;
        r.read_data = READ_IDLE;
        dch = it.data_in[1:0];
        ch  = it.chan_sel;
        case (it.op)
            OP_REG_WR: begin
                if (it.reg_index < REG_STATUS) begin
                    if (it.reg_index[0])
                        ch_count[it.reg_index[2:1]] =
                            merge_byte(ch_count[it.reg_index[2:1]], it.data_in);
                    else
                        ch_addr[it.reg_index[2:1]] =
                            merge_byte(ch_addr[it.reg_index[2:1]], it.data_in);
                end else begin
                    case (it.reg_index)
                        REG_REQUEST: begin
                            if (it.data_in[2])
                                status_q = status_q | (8'h10 << dch);
                            else
                                status_q = status_q & ~(8'h11 << dch);
                        end
                        REG_MASK_BIT: begin
                            if (it.data_in[2])
                                mask_q = mask_q | (8'h11 << dch);
                            else
                                mask_q = mask_q & ~(8'h11 << dch);
                        end
                        REG_MODE: begin
                            ch_kind[dch] = it.data_in[3:2];
                            ch_down[dch] = it.data_in[5];
                        end
                        REG_FF_CLEAR: begin
                            temp_q  = it.data_in;
                            byte_ff = 1'b0;
                        end
                        REG_MASTER_CLEAR: byte_ff = 1'b0;
                        REG_MASK_CLEAR:   mask_q = mask_q & ~it.data_in;
                        REG_MASK_SET:     mask_q = mask_q | it.data_in;
                        default: ;
                    endcase
                end
            end
            OP_REG_RD: begin
                if (it.reg_index < REG_STATUS) begin
                    v = it.reg_index[0] ? ch_count[it.reg_index[2:1]]
                                        : ch_addr[it.reg_index[2:1]];
                    r.read_data = byte_ff ? v[15:8] : v[7:0];
                    byte_ff = ~byte_ff;
                end else begin
                    case (it.reg_index)
                        REG_STATUS:       r.read_data = status_q | 8'h01;
                        REG_MASK_BIT:     r.read_data = mask_q;
                        REG_MASTER_CLEAR: r.read_data = temp_q;
                        default:          r.read_data = READ_IDLE;
                    endcase
                end
            end
            OP_MEM_TO_DEV, OP_DEV_TO_MEM: begin
                if (it.op == OP_MEM_TO_DEV && ch_kind[ch] == XK_MEM_TO_DEV) begin
                    r.mem_request = MREQ_READ;
                end else if (it.op == OP_DEV_TO_MEM && ch_kind[ch] == XK_DEV_TO_MEM) begin
                    r.mem_request    = MREQ_WRITE;
                    r.mem_write_data = it.data_in;
                end
                if (r.mem_request != MREQ_NONE)
                    r.mem_address = {ch_page[ch], ch_addr[ch]};
                // the channel steps and counts even without a matching mode
                ch_addr[ch]  = ch_down[ch] ? ch_addr[ch] - 16'd1 : ch_addr[ch] + 16'd1;
                ch_count[ch] = ch_count[ch] - 16'd1;
                if (ch_count[ch] == COUNT_WRAP) begin
                    status_q = status_q & ~(8'h10 << ch);
                    status_q = status_q | (8'h01 << ch);
                    r.terminal_count = 1'b1;
                end
            end
            OP_RESET: begin
                status_q = STATUS_RESET;
                for (int i = 0; i < NUM_CH; i++)
                    ch_kind[i] = '0;
            end
            OP_PAGE_WR: ch_page[ch] = wide_q ? it.data_in : (it.data_in & PAGE_NARROW);
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_item(logic [2:0] op, logic [3:0] idx, logic [1:0] ch,
                             logic [7:0] d);
        t_item it;
        it.op        = op;
        it.reg_index = idx;
        it.chan_sel  = ch;
        it.data_in   = d;
        pending_beats.push_back(it);
        n_pushed++;
    endtask

    function automatic logic [3:0] addr_reg(logic [1:0] ch);
        return {1'b0, ch, 1'b0};
    endfunction

    function automatic logic [3:0] count_reg(logic [1:0] ch);
        return {1'b0, ch, 1'b1};
    endfunction

    function automatic logic [7:0] mode_byte(logic [1:0] ch, logic [1:0] kind,
                                             logic down, logic [7:0] filler);
        logic [7:0] m;
        m      = filler;
        m[1:0] = ch;
        m[3:2] = kind;
        m[5]   = down;
        return m;
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() != 0 || n_accepted != n_pushed ||
               expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_wide_pages(logic v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        wide_q = v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic load_directed();
        push_item(OP_PAGE_WR, 4'h0, 2'd3, 8'hff);
        push_item(OP_REG_WR, REG_FF_CLEAR, 2'd0, 8'h5a);
        push_item(OP_REG_WR, addr_reg(2'd3), 2'd0, 8'hff);
        push_item(OP_REG_WR, addr_reg(2'd3), 2'd0, 8'hff);
        push_item(OP_REG_WR, count_reg(2'd3), 2'd0, 8'h00);
        push_item(OP_REG_WR, count_reg(2'd3), 2'd0, 8'h00);
        push_item(OP_REG_WR, REG_MODE, 2'd0, mode_byte(2'd3, XK_DEV_TO_MEM, 1'b0, 8'h00));
        // write at the top of memory, address wraps, count wraps to terminal
        push_item(OP_DEV_TO_MEM, 4'h0, 2'd3, 8'ha5);
        push_item(OP_MEM_TO_DEV, 4'h0, 2'd3, 8'h00);
        push_item(OP_REG_WR, REG_MODE, 2'd0, mode_byte(2'd0, XK_MEM_TO_DEV, 1'b1, 8'hc0));
        push_item(OP_MEM_TO_DEV, 4'hf, 2'd0, 8'hff);
        push_item(OP_REG_RD, addr_reg(2'd0), 2'd0, 8'h00);
        push_item(OP_REG_RD, addr_reg(2'd0), 2'd0, 8'h00);
        push_item(OP_REG_RD, count_reg(2'd3), 2'd0, 8'h00);
        push_item(OP_REG_RD, REG_STATUS, 2'd0, 8'h00);
        push_item(OP_REG_WR, REG_REQUEST, 2'd0, 8'h06);
        push_item(OP_REG_WR, REG_REQUEST, 2'd0, 8'h01);
        push_item(OP_REG_WR, REG_MASK_BIT, 2'd0, 8'h05);
        push_item(OP_REG_WR, REG_MASK_SET, 2'd0, 8'hf0);
        push_item(OP_REG_WR, REG_MASK_CLEAR, 2'd0, 8'h11);
        push_item(OP_REG_RD, REG_MASK_BIT, 2'd0, 8'h00);
        push_item(OP_REG_RD, REG_MASTER_CLEAR, 2'd0, 8'h00);
        push_item(OP_REG_WR, REG_MASTER_CLEAR, 2'd0, 8'h00);
        push_item(OP_REG_WR, REG_STATUS, 2'd0, 8'hff);   // command write, ignored
        push_item(OP_REG_RD, REG_REQUEST, 2'd0, 8'h00);  // write-only offset
        push_item(OP_RESET, 4'h0, 2'd0, 8'h00);
        push_item(OP_REG_RD, REG_STATUS, 2'd0, 8'h00);
        push_item(3'd6, 4'hf, 2'd3, 8'hff);
        push_item(3'd7, 4'hf, 2'd3, 8'hff);
    endtask

    task automatic gen_traffic(int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        logic [1:0]  ch;
        target = n_pushed + n_items;
        while (n_pushed < target) begin
            pick = $urandom_range(0, 9);
            ch   = 2'($urandom_range(0, 3));
            case (pick)
                0, 1: push_item(3'($urandom_range(0, 7)), 4'($urandom), 2'($urandom),
                                8'($urandom));
                2, 3: begin
                    // full channel setup, short counts so terminal count comes often
                    push_item(OP_REG_WR, REG_FF_CLEAR, 2'($urandom), 8'($urandom));
                    push_item(OP_REG_WR, addr_reg(ch), 2'($urandom), 8'($urandom));
                    push_item(OP_REG_WR, addr_reg(ch), 2'($urandom), 8'($urandom));
                    push_item(OP_REG_WR, count_reg(ch), 2'($urandom),
                              8'($urandom_range(0, 5)));
                    push_item(OP_REG_WR, count_reg(ch), 2'($urandom),
                              8'(($urandom_range(0, 7) == 0) ? $urandom : 0));
                    push_item(OP_REG_WR, REG_MODE, 2'($urandom),
                              mode_byte(ch, 2'($urandom_range(0, 3)), 1'($urandom),
                                        8'($urandom)));
                    push_item(OP_PAGE_WR, 4'($urandom), ch, 8'($urandom));
                end
                4, 5, 6, 7: begin
                    repeat ($urandom_range(1, 8))
                        push_item($urandom_range(0, 1) ? OP_MEM_TO_DEV : OP_DEV_TO_MEM,
                                  4'($urandom), ch, 8'($urandom));
                end
                8: begin
                    push_item(OP_REG_RD, 4'($urandom), 2'($urandom), 8'($urandom));
                    push_item(OP_REG_RD, 4'($urandom_range(0, 7)), 2'($urandom),
                              8'($urandom));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: push_item(OP_REG_WR, 4'($urandom_range(0, 7)), 2'($urandom),
                                     8'($urandom));
                        1: push_item(OP_RESET, 4'($urandom), 2'($urandom), 8'($urandom));
                        2: push_item(OP_REG_WR,
                                     4'($urandom_range(REG_REQUEST, REG_MASK_SET)),
                                     2'($urandom), 8'($urandom));
                        default: push_item(OP_REG_RD, REG_STATUS, 2'($urandom),
                                           8'($urandom));
                    endcase
                end
            endcase
        end
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
            n_errors++;
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_item it;
        logic  nv;
        if (i_rst_n) begin
            nv = in_if.valid;
            if (!in_if.valid || in_taken) begin
                nv = 1'b0;
                if (src_gap != 0) begin
                    src_gap--;
                end else if (pending_beats.size() != 0) begin
                    it = pending_beats.pop_front();
                    in_if.op        <= it.op;
                    in_if.reg_index <= it.reg_index;
                    in_if.chan_sel  <= it.chan_sel;
                    in_if.data_in   <= it.data_in;
                    nv = 1'b1;
                    if (idle_now && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 5);
                end
            end
            in_if.valid <= nv;
        end
    end

    // result-side backpressure
    always @(negedge i_clk) begin
        logic nr;
        if (i_rst_n) begin
            nr = 1'b1;
            if (snk_stall != 0) begin
                nr = 1'b0;
                snk_stall--;
            end else if (idle_now && $urandom_range(0, 5) == 0) begin
                nr = 1'b0;
                snk_stall = $urandom_range(1, 5) - 1;
            end
            out_if.ready <= nr;
        end
    end

    // monitor: check result beats, predict on accepted input beats
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            in_taken = in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %0h/%0h/%0h",
                             $realtime, out_if.read_data, out_if.mem_request,
                             out_if.mem_address);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", 24'(want.read_data), 24'(out_if.read_data));
                    check_field("mem_request", 24'(want.mem_request),
                                24'(out_if.mem_request));
                    check_field("mem_address", want.mem_address, out_if.mem_address);
                    check_field("mem_write_data", 24'(want.mem_write_data),
                                24'(out_if.mem_write_data));
                    check_field("terminal_count", 24'(want.terminal_count),
                                24'(out_if.terminal_count));
                    n_checked++;
                    if (want.mem_request != MREQ_NONE)
                        n_mem++;
                    if (want.terminal_count)
                        n_tc++;
                end
            end
            if (in_taken) begin
                expected_results.push_back(dma_predict('{op: in_if.op,
                    reg_index: in_if.reg_index, chan_sel: in_if.chan_sel,
                    data_in: in_if.data_in}));
                n_accepted++;
            end
        end else begin
            in_taken = 1'b0;
        end
    end

    // idle windows and run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 64 == 0)
            idle_now = idle_en && ($urandom_range(0, 2) != 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d results outstanding",
                     $realtime, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 1'b0;
        in_if.valid     = 1'b0;
        in_if.op        = '0;
        in_if.reg_index = '0;
        in_if.chan_sel  = '0;
        in_if.data_in   = '0;
        out_if.ready    = 1'b0;
        reset_model();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_wide_pages(1'b1);
        load_directed();
        wait_idle();

        set_wide_pages(1'b0);
        gen_traffic(150);
        wait_idle();
        gen_traffic(150);
        wait_idle();

        set_wide_pages(1'b1);
        gen_traffic(250);
        wait_idle();

        // closing stretch at full rate on both sides
        idle_en  = 1'b0;
        idle_now = 1'b0;
        set_wide_pages(1'b0);
        gen_traffic(250);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d result beats: %0d memory accesses, %0d terminal counts,",
                 n_checked, n_mem, n_tc);
        $display("over directed register cases and random traffic in both page widths.");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
